// ----- rtl/assert_macros.svh -----
// Assertion macros for the heading pipeline RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is high.
`define CMH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
// Clocked check that also holds through reset.
`define CMH_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define CMH_ASSERT(lbl, clk, rst, prop)
`define CMH_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- rtl/cmh_pkg.sv -----
// Types, widths, constants and the arctangent table of the compass heading pipeline.
package cmh_pkg;

  // Number of CORDIC iterations, one pipeline stage each (8 to 24).
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;

  // Field widths.
  localparam int RAW_W  = 16;
  localparam int GAIN_W = 18;
  localparam int OFS_W  = 17;
  localparam int DECL_W = 16;
  localparam int HEAD_W = 16;
  localparam int FRAC_W = 16;

  // Calibration product, calibrated sum, CORDIC vector and angle widths.
  localparam int PROD_W = RAW_W + GAIN_W;
  localparam int CAL_W  = PROD_W + 1;
  localparam int VEC_W  = CAL_W + 3;
  localparam int ANG_W  = 33;
  localparam int SUM_W  = HEAD_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // Angles in hundredths of a degree and in 1/65536 of a hundredth.
  localparam int FULL_TURN = 36000;
  localparam logic signed [ANG_W-1:0] ANG_FULL  = 33'sd2359296000;
  localparam logic signed [ANG_W-1:0] ANG_HALF  = 33'sd1179648000;
  localparam logic [ANG_W-1:0]        ANG_ROUND = 33'd32768;

  // Reset values of the registers.
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = 18'sd65536;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_XX  = 3'd0,
    REG_GAIN_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_GAIN_YX  = 3'd3,
    REG_GAIN_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_DECL     = 3'd6
  } cfg_reg_e;

  // Request payloads on the two channels.
  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              no_data;
  } result_t;

  // Calibration coefficients handed to the calibration stages.
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_xx;
    logic signed [GAIN_W-1:0] gain_xy;
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [GAIN_W-1:0] gain_yx;
    logic signed [GAIN_W-1:0] gain_yy;
    logic signed [OFS_W-1:0]  offset_y;
  } cal_cfg_t;

  // Calibrated vector between calibration and CORDIC.
  typedef struct packed {
    logic signed [CAL_W-1:0] cx;
    logic signed [CAL_W-1:0] cy;
    logic                    empty;
  } cal_t;

  // Raw CORDIC angle between CORDIC and the finishing stages.
  typedef struct packed {
    logic signed [ANG_W-1:0] z;
    logic                    empty;
    logic                    zero;
  } ang_t;

  // atan(2^-i) in 1/65536 of a hundredth of a degree, rounded.
  function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = 33'sd294912000;
      1:       v = 33'sd174096719;
      2:       v = 33'sd91987925;
      3:       v = 33'sd46694507;
      4:       v = 33'sd23437865;
      5:       v = 33'sd11730358;
      6:       v = 33'sd5866609;
      7:       v = 33'sd2933484;
      8:       v = 33'sd1466764;
      9:       v = 33'sd733385;
      10:      v = 33'sd366693;
      11:      v = 33'sd183346;
      12:      v = 33'sd91673;
      13:      v = 33'sd45837;
      14:      v = 33'sd22918;
      15:      v = 33'sd11459;
      16:      v = 33'sd5730;
      17:      v = 33'sd2865;
      18:      v = 33'sd1432;
      19:      v = 33'sd716;
      20:      v = 33'sd358;
      21:      v = 33'sd179;
      22:      v = 33'sd90;
      23:      v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/compass_heading_from_magnetometer.sv -----
// Top level of the compass heading pipeline: registers, stage chain and checks.
//
// A magnetometer X/Y pair enters on the sample channel (sample_valid /
// sample_ready) and one heading request leaves on the result channel
// (result_valid / result_ready) for every sample, in order. The heading is
// in hundredths of a degree, 0 to 35999, with the declination added; no_data
// marks a sample whose raw X and Y were both zero.
// The pipeline has two calibration stages, one fold stage, one stage per
// CORDIC iteration and three finishing stages. A new sample is taken in
// every cycle unless a receiver stall has filled the pipeline; the rate is
// set by the one-iteration-per-stage CORDIC chain.
// When the receiver stalls, the stages fill up from the output backwards;
// sample_ready falls only once every stage holds a request.
// Reset empties the pipeline and loads the calibration with the identity
// map and zero declination. The user writes registers (cfg_we, cfg_addr,
// cfg_wdata) only while the pipeline is empty; no logic here checks that.
`include "assert_macros.svh"

module compass_heading_from_magnetometer import cmh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  cal_cfg_t                cal_cfg;
  logic signed [DECL_W-1:0] decl;
  logic                    cal_valid;
  logic                    cal_ready;
  cal_t                    cal_data;
  logic                    ang_valid;
  logic                    ang_ready;
  ang_t                    ang_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_cfg.gain_xx  <= GAIN_ONE;
      cal_cfg.gain_xy  <= '0;
      cal_cfg.offset_x <= '0;
      cal_cfg.gain_yx  <= '0;
      cal_cfg.gain_yy  <= GAIN_ONE;
      cal_cfg.offset_y <= '0;
      decl             <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_GAIN_XX:  cal_cfg.gain_xx  <= cfg_wdata;
        REG_GAIN_XY:  cal_cfg.gain_xy  <= cfg_wdata;
        REG_OFFSET_X: cal_cfg.offset_x <= cfg_wdata[OFS_W-1:0];
        REG_GAIN_YX:  cal_cfg.gain_yx  <= cfg_wdata;
        REG_GAIN_YY:  cal_cfg.gain_yy  <= cfg_wdata;
        REG_OFFSET_Y: cal_cfg.offset_y <= cfg_wdata[OFS_W-1:0];
        REG_DECL:     decl             <= cfg_wdata[DECL_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibration, angle and heading stages.
  cmh_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cal_cfg),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .in_data   (sample),
    .out_valid (cal_valid),
    .out_ready (cal_ready),
    .out_data  (cal_data)
  );

  cmh_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cal_valid),
    .in_ready  (cal_ready),
    .in_data   (cal_data),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_data  (ang_data)
  );

  cmh_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .decl      (decl),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_data   (ang_data),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

  // Checks on the pipeline and the register file.
  `CMH_ASSERT(a_heading_range, clk, rst, result_valid |-> (result.heading < HEAD_W'(FULL_TURN)))
  `CMH_ASSERT(a_full_only_on_stall, clk, rst, !sample_ready |-> (result_valid && !result_ready))
  `CMH_ASSERT_NR(a_reset_flush, clk, rst |=> !result_valid)
  `CMH_ASSERT(a_decl_write, clk, rst, (cfg_we && (cfg_addr == REG_DECL)) |=> (decl == $past(cfg_wdata[DECL_W-1:0])))

endmodule

// ----- rtl/cmh_calib.sv -----
// Two-stage affine calibration: four multiplies, then the two row sums.
module cmh_calib import cmh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cal_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  sample_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cal_t     out_data
);

  logic                     prod_valid;
  logic                     prod_empty;
  logic signed [PROD_W-1:0] p_xx;
  logic signed [PROD_W-1:0] p_xy;
  logic signed [PROD_W-1:0] p_yx;
  logic signed [PROD_W-1:0] p_yy;
  logic                     sum_valid;
  logic                     sum_ready;
  cal_t                     sum;
  logic signed [CAL_W-1:0]  ofs_x_ext;
  logic signed [CAL_W-1:0]  ofs_y_ext;

  // A stage takes a new request when it is empty or its contents move on.
  assign sum_ready = !sum_valid || out_ready;
  assign in_ready  = !prod_valid || sum_ready;

  // Offsets are in raw counts, so they are aligned with the Q.16 products.
  assign ofs_x_ext = {{(CAL_W-OFS_W-FRAC_W){cfg.offset_x[OFS_W-1]}}, cfg.offset_x,
                      {FRAC_W{1'b0}}};
  assign ofs_y_ext = {{(CAL_W-OFS_W-FRAC_W){cfg.offset_y[OFS_W-1]}}, cfg.offset_y,
                      {FRAC_W{1'b0}}};

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_xx       <= PROD_W'(in_data.raw_x) * PROD_W'(cfg.gain_xx);
      p_xy       <= PROD_W'(in_data.raw_y) * PROD_W'(cfg.gain_xy);
      p_yx       <= PROD_W'(in_data.raw_x) * PROD_W'(cfg.gain_yx);
      p_yy       <= PROD_W'(in_data.raw_y) * PROD_W'(cfg.gain_yy);
      prod_empty <= (in_data.raw_x == '0) && (in_data.raw_y == '0);
    end
  end

  // Row sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && prod_valid) begin
      sum.cx    <= CAL_W'(p_xx) + CAL_W'(p_xy) + ofs_x_ext;
      sum.cy    <= CAL_W'(p_yx) + CAL_W'(p_yy) + ofs_y_ext;
      sum.empty <= prod_empty;
    end
  end

  assign out_valid = sum_valid;
  assign out_data  = sum;

endmodule

// ----- rtl/cmh_cordic.sv -----
// Vectoring CORDIC: a half-plane fold stage, then one stage per iteration.
module cmh_cordic import cmh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cal_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ang_t out_data
);

  logic                    v     [CORDIC_STEPS+1];
  logic                    rdy   [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] x     [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] y     [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z     [CORDIC_STEPS+1];
  logic                    empty [CORDIC_STEPS+1];
  logic                    zero  [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] cx_ext;
  logic signed [VEC_W-1:0] cy_ext;

  // Ready travels back through the stages so that bubbles are filled.
  assign rdy[CORDIC_STEPS] = !v[CORDIC_STEPS] || out_ready;
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  assign cx_ext = VEC_W'(in_data.cx);
  assign cy_ext = VEC_W'(in_data.cy);

  // Fold stage: a vector in the left half plane is negated and starts at 180 degrees.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      if (in_data.cx[CAL_W-1]) begin
        x[0] <= -cx_ext;
        y[0] <= -cy_ext;
        z[0] <= ANG_HALF;
      end else begin
        x[0] <= cx_ext;
        y[0] <= cy_ext;
        z[0] <= '0;
      end
      zero[0]  <= (in_data.cx == '0) && (in_data.cy == '0);
      empty[0] <= in_data.empty;
    end
  end

  // Iteration stages: rotate towards the x axis by atan(2^-i).
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_step(i);
    logic y_pos;

    assign y_pos = !y[i][VEC_W-1] && (y[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (rdy[i+1]) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i+1] && v[i]) begin
        if (y_pos) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_I;
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_I;
        end
        zero[i+1]  <= zero[i];
        empty[i+1] <= empty[i];
      end
    end
  end

  assign out_valid      = v[CORDIC_STEPS];
  assign out_data.z     = z[CORDIC_STEPS];
  assign out_data.empty = empty[CORDIC_STEPS];
  assign out_data.zero  = zero[CORDIC_STEPS];

endmodule

// ----- rtl/cmh_finish.sv -----
// Angle wrap, rounding to hundredths, and the declination add, one stage each.
module cmh_finish import cmh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DECL_W-1:0] decl,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ang_t                     in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output result_t                  out_data
);

  logic                    v1;
  logic                    v2;
  logic                    v3;
  logic                    r2;
  logic                    r3;
  logic [ANG_W-2:0]        zw;
  logic                    empty1;
  logic                    empty2;
  logic [HEAD_W-1:0]       h2;
  logic [ANG_W-1:0]        z_round;
  logic signed [SUM_W-1:0] h_sum;
  logic [HEAD_W-1:0]       h_next;
  result_t                 res;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign in_ready = !v1 || r2;

  // Wrap stage: a negative angle gets a full turn; no data or a zero vector gives 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      if (in_data.empty || in_data.zero) begin
        zw <= '0;
      end else if (in_data.z[ANG_W-1]) begin
        zw <= (ANG_W-1)'(in_data.z + ANG_FULL);
      end else begin
        zw <= (ANG_W-1)'(in_data.z);
      end
      empty1 <= in_data.empty;
    end
  end

  // Round stage: half up to hundredths, with a full turn folded back to 0.
  assign z_round = {1'b0, zw} + ANG_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      if (z_round[FRAC_W+HEAD_W-1:FRAC_W] == HEAD_W'(FULL_TURN)) begin
        h2 <= '0;
      end else begin
        h2 <= z_round[FRAC_W+HEAD_W-1:FRAC_W];
      end
      empty2 <= empty1;
    end
  end

  // Declination stage: add and wrap once by a full turn.
  assign h_sum = SUM_W'({2'b00, h2}) + SUM_W'(decl);

  always_comb begin
    if (h_sum[SUM_W-1]) begin
      h_next = HEAD_W'(h_sum + SUM_W'(FULL_TURN));
    end else if (h_sum >= SUM_W'(FULL_TURN)) begin
      h_next = HEAD_W'(h_sum - SUM_W'(FULL_TURN));
    end else begin
      h_next = HEAD_W'(h_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      res.heading <= h_next;
      res.no_data <= empty2;
    end
  end

  assign out_valid = v3;
  assign out_data  = res;

endmodule

// ----- bench/compass_heading_from_magnetometer_test.sv -----
// Self-checking testbench for the compass heading pipeline.
`timescale 1ns / 1ps

module compass_heading_from_magnetometer_test;
  import cmh_pkg::*;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int PIPE_LATENCY = CORDIC_STEPS + 6;
  localparam int CYCLE_LIMIT = 400000;

  // Angle constants in 1/65536 of a hundredth of a degree.
  localparam longint FRAC_ONE = 64'sd65536;
  localparam longint HALF_UNIT = 64'sd32768;
  localparam longint HALF_TURN_Z = 64'sd1179648000;
  localparam longint FULL_TURN_Z = 64'sd2359296000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic sample_valid;
  logic sample_ready;
  sample_t sample;
  logic result_valid;
  logic result_ready;
  result_t result;

  // Local copy of the calibration registers.
  longint cal_gxx, cal_gxy, cal_ox, cal_gyx, cal_gyy, cal_oy, cal_decl;

  // Arctangent of 2^-i in 1/65536 of a hundredth of a degree.
  longint atan_z [0:ATAN_ENTRIES-1] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866609, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  result_t pending_headings [$];
  int mismatch_count = 0;
  int cycle_count = 0;

  // Idling controls and the long receiver hold-off.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  compass_heading_from_magnetometer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when one is asked for.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every accepted result with the oldest predicted heading.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_headings.size() == 0) begin
        $error("unexpected result: heading %0d, no_data %0d", result.heading, result.no_data);
        mismatch_count++;
      end else begin
        want = pending_headings.pop_front();
        if (result.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, result.heading);
          mismatch_count++;
        end
        if (result.no_data !== want.no_data) begin
          $error("no_data: expected %0d, got %0d", want.no_data, result.no_data);
          mismatch_count++;
        end
      end
    end
  end

  // Heading of one sample under the current calibration: affine map, vectoring
  // CORDIC, rounding to hundredths, then the declination with wrap-around.
  function automatic result_t heading_of(sample_t s);
    longint rx, ry, x, y, z, dx, dy, h;
    int i;
    result_t r;
    rx = $signed(s.raw_x);
    ry = $signed(s.raw_y);
    h = 0;
    r.no_data = (rx == 0 && ry == 0);
    if (!r.no_data) begin
      x = rx * cal_gxx + ry * cal_gxy + cal_ox * FRAC_ONE;
      y = rx * cal_gyx + ry * cal_gyy + cal_oy * FRAC_ONE;
      z = 0;
      if (x != 0 || y != 0) begin
        // The left half plane is folded over and starts from 180 degrees.
        if (x < 0) begin
          x = -x;
          y = -y;
          z = HALF_TURN_Z;
        end
        for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y > 0) begin
            x += dx;
            y -= dy;
            z += atan_z[i];
          end else begin
            x -= dx;
            y += dy;
            z -= atan_z[i];
          end
        end
        if (z < 0) z += FULL_TURN_Z;
      end
      h = (z + HALF_UNIT) >>> FRAC_W;
      if (h >= FULL_TURN) h -= FULL_TURN;
    end
    h += cal_decl;
    if (h < 0) h += FULL_TURN;
    else if (h >= FULL_TURN) h -= FULL_TURN;
    r.heading = h[HEAD_W-1:0];
    return r;
  endfunction

  function automatic sample_t make_sample(int x, int y);
    sample_t s;
    s.raw_x = 16'(x);
    s.raw_y = 16'(y);
    return s;
  endfunction

  // Mostly full-range samples, with zero pairs, axis points and tiny vectors.
  function automatic sample_t random_sample();
    case ($urandom_range(15))
      0:       return make_sample(0, 0);
      1:       return make_sample(0, $urandom);
      2:       return make_sample($urandom, 0);
      3, 4:    return make_sample(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
      default: return make_sample($urandom, $urandom);
    endcase
  endfunction

  // Offer one sample, with a random gap first; returns on the edge it is taken.
  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    pending_headings.push_back(heading_of(s));
  endtask

  task automatic wait_for_results();
    sample_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  // Holds the write strobe high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_GAIN_XX:  cal_gxx = $signed(data);
      REG_GAIN_XY:  cal_gxy = $signed(data);
      REG_OFFSET_X: cal_ox = $signed(data[OFS_W-1:0]);
      REG_GAIN_YX:  cal_gyx = $signed(data);
      REG_GAIN_YY:  cal_gyy = $signed(data);
      REG_OFFSET_Y: cal_oy = $signed(data[OFS_W-1:0]);
      REG_DECL:     cal_decl = $signed(data[DECL_W-1:0]);
      default:      ;
    endcase
  endtask

  // Load a full calibration once the pipeline has emptied, plus a stray write.
  task automatic set_calibration(logic [CFG_DATA_W-1:0] gxx, logic [CFG_DATA_W-1:0] gxy,
                                 logic [CFG_DATA_W-1:0] ox, logic [CFG_DATA_W-1:0] gyx,
                                 logic [CFG_DATA_W-1:0] gyy, logic [CFG_DATA_W-1:0] oy,
                                 logic [CFG_DATA_W-1:0] decl);
    wait_for_results();
    write_reg(REG_GAIN_XX, gxx);
    write_reg(REG_GAIN_XY, gxy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_GAIN_YX, gyx);
    write_reg(REG_GAIN_YY, gyy);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_DECL, decl);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Identity calibration from reset: axes, corners and the left half plane.
  task automatic test_reset_calibration();
    send_sample(make_sample(0, 0));
    send_sample(make_sample(32767, 0));
    send_sample(make_sample(-32768, 0));
    send_sample(make_sample(0, 32767));
    send_sample(make_sample(0, -32768));
    send_sample(make_sample(32767, 32767));
    send_sample(make_sample(-32768, -32768));
    send_sample(make_sample(-32768, 32767));
    send_sample(make_sample(32767, -32768));
    send_sample(make_sample(-1, 0));
    send_sample(make_sample(-1, -1));
    send_sample(make_sample(1, -1));
  endtask

  // Vectors that calibrate to zero, and declinations in and out of range.
  task automatic test_zero_vectors_and_declination();
    set_calibration(GAIN_ONE, '0, 18'(-100), '0, '0, '0, 18'(18000));
    send_sample(make_sample(100, 5));
    send_sample(make_sample(0, 0));
    set_calibration('0, '0, '0, '0, '0, '0, 18'(-18000));
    send_sample(make_sample(1234, -77));
    send_sample(make_sample(0, 0));
    set_calibration(GAIN_ONE, '0, '0, '0, GAIN_ONE, '0, 18'(32767));
    send_sample(make_sample(0, 0));
    send_sample(make_sample(3, 4));
    set_calibration(GAIN_ONE, '0, '0, '0, GAIN_ONE, '0, 18'(-32768));
    send_sample(make_sample(0, 0));
    send_sample(make_sample(-3, 4));
  endtask

  // Largest and smallest coefficients with full-scale samples.
  task automatic test_extreme_calibration();
    set_calibration(18'h1FFFF, 18'h1FFFF, 18'(65535), 18'h1FFFF, 18'h1FFFF, 18'(65535),
                    18'(18000));
    send_sample(make_sample(32767, 32767));
    send_sample(make_sample(-32768, -32768));
    send_sample(make_sample(32767, -32768));
    send_sample(make_sample(-32768, 32767));
    set_calibration(18'h20000, 18'h20000, 18'(-65536), 18'h20000, 18'h20000, 18'(-65536),
                    18'(-18000));
    send_sample(make_sample(32767, 32767));
    send_sample(make_sample(-32768, -32768));
    send_sample(make_sample(32767, -32768));
    send_sample(make_sample(-32768, 32767));
  endtask

  // Random samples under random calibrations, through each idling pattern.
  task automatic test_random_traffic();
    int phase, k, n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 70; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 6;  stall_pct = 6;  end
      endcase
      for (k = 0; k < 4; k++) begin
        // Either any register contents, or a calibration near the identity.
        if ($urandom_range(1))
          set_calibration(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom));
        else
          set_calibration(18'(GAIN_ONE + $urandom_range(8191) - 4096),
                          18'($urandom_range(8191) - 4096),
                          18'($urandom_range(4095) - 2048),
                          18'($urandom_range(8191) - 4096),
                          18'(GAIN_ONE + $urandom_range(8191) - 4096),
                          18'($urandom_range(4095) - 2048),
                          18'($urandom_range(36000) - 18000));
        for (n = 0; n < 40; n++) send_sample(random_sample());
      end
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_output_backpressure();
    int n;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 300;
    hold_seq++;
    for (n = 0; n < 80; n++) send_sample(random_sample());
  endtask

  // The sender stops until every heading is back, then carries on.
  task automatic test_sender_pause();
    int n;
    send_idle_pct = 20;
    stall_pct = 20;
    for (n = 0; n < 20; n++) send_sample(random_sample());
    wait_for_results();
    for (n = 0; n < 20; n++) send_sample(random_sample());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    sample_valid = 1'b0;
    sample = '0;
    result_ready = 1'b0;
    cal_gxx = GAIN_ONE;
    cal_gxy = 0;
    cal_ox = 0;
    cal_gyx = 0;
    cal_gyy = GAIN_ONE;
    cal_oy = 0;
    cal_decl = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_calibration();
    test_zero_vectors_and_declination();
    test_extreme_calibration();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();

    // Let any stray result show up before the verdict.
    wait_for_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
